[design/rei_pkg.sv]
// Shared constants, types and a helper function for the retention error injector.
package rei_pkg;

  // Number of stamp table entries; must be a power of two.
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
  localparam int RATE_FRACTION_BITS = 8;

  localparam int RATE_W = 24;
  localparam int STAMP_W = 64;
  localparam int PROD_W = 64 + RATE_W;
  localparam int HALF_W = 32;
  localparam int PART_W = HALF_W + RATE_W;

  localparam logic [63:0] PRNG_SEED = 64'd12345;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // Word index of the configuration register.
  localparam logic REG_FLIP_RATE = 1'b0;

  localparam logic [3:0] MAX_SIZE = 4'd8;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_STORE  = 10'b00_0000_0100,
    S_READ   = 10'b00_0000_1000,
    S_WAIT   = 10'b00_0001_0000,
    S_MUL_LO = 10'b00_0010_0000,
    S_MUL_HI = 10'b00_0100_0000,
    S_THRESH = 10'b00_1000_0000,
    S_DRAW   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  // One step of the 64-bit xorshift generator.
  function automatic logic [63:0] xorshift_step(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x >> 21);
    b = a ^ (a << 35);
    return b ^ (b >> 4);
  endfunction

endpackage

[design/rei_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module rei_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/retention_error_injector.sv]
// Top level of the retention error injector: sequencer, stamp table and flip generator.
//
// The block models bit errors in memory with slowed refresh. A store stamps each of its
// bytes with cycle_now in a direct-mapped table; a load reads each byte's stamp, turns the
// elapsed cycles into a flip threshold and tests the byte's 8 bits against 8 successive
// xorshift draws, then restamps the byte. After reset the block sweeps all TABLE_ENTRIES
// (1024) entries of the stamp table to zero, one entry per cycle, and holds in_ready low
// until the sweep is done. One transaction is worked at a time: a store writes one stamp
// per byte; a load works each byte in turn (table read, elapsed subtract, two passes
// through the shared 32x24 multiplier, threshold, then one generator step per bit); a
// misaligned or zero-size access goes straight to S_DONE. The finished result sits in an
// output register, so the next transaction is taken while it waits for out_ready.
module retention_error_injector
  import rei_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [63:0]           address,
  input  logic [3:0]            alignment,
  input  logic [63:0]           cycle_now,
  input  logic [3:0]            size_bytes,
  input  logic [63:0]           load_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           result_value,
  output logic                  misaligned,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t              state;
  logic [TABLE_AW-1:0] clr_idx;
  logic                is_load;
  logic                mis;
  logic [TABLE_AW-1:0] addr_lo;
  logic [63:0]         now;
  logic [3:0]          size;
  logic [63:0]         value;
  logic [3:0]          k;
  logic [2:0]          j;
  logic [63:0]         elapsed;
  logic [PART_W-1:0]   p_lo;
  logic [PART_W-1:0]   p_hi;
  logic [63:0]         thr;
  logic [63:0]         prng;
  logic [RATE_W-1:0]   flip_rate;

  logic                in_fire;
  logic                in_mis;
  logic [TABLE_AW-1:0] slot;
  logic                ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic [STAMP_W-1:0]  ram_wdata;
  logic [STAMP_W-1:0]  ram_rdata;
  logic [HALF_W-1:0]   mul_a;
  logic [PART_W-1:0]   mul_out;
  logic [PROD_W-1:0]   prod;
  logic [63:0]         thr_next;
  logic [63:0]         prng_next;
  logic                hit;
  logic                last_byte;
  logic                out_free;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_FLIP_RATE);
  assign prdata  = (paddr[2] == REG_FLIP_RATE) ? CFG_DATA_W'(flip_rate) : '0;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_mis   = (alignment != 4'd0) && ((address[3:0] & (alignment - 4'd1)) != 4'd0);

  assign slot      = addr_lo + TABLE_AW'(k);
  assign last_byte = ((k + 4'd1) == size);
  assign out_free  = !out_valid || out_ready;

  // Shared multiplier: low half of elapsed first, then the high half.
  assign mul_a   = (state == S_MUL_LO) ? elapsed[HALF_W-1:0] : elapsed[63:HALF_W];
  assign mul_out = PART_W'(mul_a) * PART_W'(flip_rate);

  assign prod = PROD_W'(p_lo) + (PROD_W'(p_hi) << HALF_W);
  assign thr_next = (prod[PROD_W-1:64+RATE_FRACTION_BITS] != '0) ? '1 :
                    prod[64+RATE_FRACTION_BITS-1:RATE_FRACTION_BITS];

  assign prng_next = xorshift_step(prng);
  assign hit       = (prng_next < thr);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = now;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_STORE, S_THRESH: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rei_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_rate <= '0;
    end else if (cfg_wr) begin
      flip_rate <= pwdata[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      prng      <= PRNG_SEED;
      out_valid <= 1'b0;
    end else begin
      // In S_DONE a departing result is replaced by the new one in the same cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + TABLE_AW'(1);
          if (clr_idx == TABLE_AW'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            is_load <= req_type;
            mis     <= in_mis;
            addr_lo <= address[TABLE_AW-1:0];
            now     <= cycle_now;
            size    <= (size_bytes > MAX_SIZE) ? MAX_SIZE : size_bytes;
            value   <= in_mis ? '0 : load_value;
            k       <= '0;
            j       <= '0;
            if (in_mis || size_bytes == 4'd0) begin
              state <= S_DONE;
            end else if (req_type) begin
              state <= S_READ;
            end else begin
              state <= S_STORE;
            end
          end
        end
        S_STORE: begin
          k <= k + 4'd1;
          if (last_byte) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          elapsed <= now - ram_rdata;
          state   <= S_MUL_LO;
        end
        S_MUL_LO: begin
          p_lo  <= mul_out;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          p_hi  <= mul_out;
          state <= S_THRESH;
        end
        S_THRESH: begin
          thr   <= thr_next;
          state <= S_DRAW;
        end
        S_DRAW: begin
          prng <= prng_next;
          value[{k[2:0], j}] <= value[{k[2:0], j}] ^ hit;
          j <= j + 3'd1;
          if (j == 3'd7) begin
            k <= k + 4'd1;
            state <= last_byte ? S_DONE : S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_value <= is_load ? value : '0;
            misaligned   <= mis;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/rei_checker.sv]
// Port-level checker for the retention error injector, bound to the top level.
module rei_checker
  import rei_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_value,
  input logic        misaligned,
  input logic [CFG_DATA_W-1:0] prdata
);

  // A refused access never carries data.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && misaligned |-> result_value == 64'd0)
    else $error("misaligned result carries nonzero data");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(misaligned))
    else $error("stalled result changed");

  // Only one transaction is worked at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  // The table sweep after reset keeps the input closed.
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready && !out_valid)
    else $error("block open right after reset");

  // The rate register holds only its low bits.
  assert property (@(posedge clk) disable iff (rst)
    prdata[CFG_DATA_W-1:RATE_W] == '0)
    else $error("readback has bits above the rate field");

endmodule

bind retention_error_injector rei_checker u_rei_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .misaligned   (misaligned),
  .prdata       (prdata)
);
